>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros for the rectangle region finder
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property sampled on the rising clock, off while reset is low
`define MRRF_ASSERT(lbl, clk_i, rstn_i, prop, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (prop)) else $error(msg);

// same-cycle implication
`define MRRF_ASSERT_IMP(lbl, clk_i, rstn_i, ante, cons, msg) \
	`MRRF_ASSERT(lbl, clk_i, rstn_i, (ante) |-> (cons), msg)

`endif

>>> sv/mrrf_pkg.sv
// ----------------------------------------------------------------------------
// mrrf_pkg
// types and constants shared by the rectangle region finder modules
// ----------------------------------------------------------------------------
`default_nettype none

package mrrf_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 7;

	localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 1'd1;

	// output field widths
	localparam int CAT_W  = 2;
	localparam int ROW_W  = 6;
	localparam int COL_W  = 6;
	localparam int HGT_W  = 7;
	localparam int WID_W  = 7;
	localparam int AREA_W = 13;

	localparam int NUM_RECORDS = 3;

	// record categories
	localparam logic [CAT_W-1:0] CAT_HEIGHT = 2'd0;
	localparam logic [CAT_W-1:0] CAT_WIDTH  = 2'd1;
	localparam logic [CAT_W-1:0] CAT_AREA   = 2'd2;

	typedef struct packed {
		logic [AREA_W-1:0] region_area;
		logic [WID_W-1:0]  region_width;
		logic [HGT_W-1:0]  region_height;
		logic [COL_W-1:0]  left_col;
		logic [ROW_W-1:0]  top_row;
	} rec_t;

	typedef struct packed {
		logic busy;
		logic done;
	} scan_stat_t;

	typedef enum logic [2:0] {
		SC_IDLE,
		SC_READ,
		SC_CHECK,
		SC_WIDTH,
		SC_HEIGHT,
		SC_MARK,
		SC_UPDATE
	} scan_state_t;

endpackage

`default_nettype wire

>>> sv/mrrf_ram.sv
// ----------------------------------------------------------------------------
// mrrf_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module mrrf_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> sv/mrrf_scan.sv
// ----------------------------------------------------------------------------
// mrrf_scan
// raster scan sequencer: finds regions, marks them visited, keeps records
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mrrf_scan #(
	parameter int MAX_SIDE = 64,
	localparam int CELLS   = MAX_SIDE * MAX_SIDE,
	localparam int AW      = (CELLS > 1) ? $clog2(CELLS) : 1,
	localparam int SW      = $clog2(MAX_SIDE + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [SW-1:0]         num_rows,
	input  logic [SW-1:0]         num_cols,
	output logic [AW-1:0]         rd_addr,
	input  logic                  img_bit,
	input  logic                  vis_bit,
	output logic                  mark_we,
	output logic [AW-1:0]         mark_addr,
	output mrrf_pkg::scan_stat_t  stat,
	output mrrf_pkg::rec_t        rec_height,
	output mrrf_pkg::rec_t        rec_width,
	output mrrf_pkg::rec_t        rec_area
);

	localparam int IW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
	localparam int EW = SW + 1;
	localparam int PW = 2 * SW;

	typedef struct packed {
		logic [IW-1:0] row;
		logic [IW-1:0] col;
		logic [SW-1:0] height;
		logic [SW-1:0] width;
		logic [PW-1:0] area;
	} cand_t;

	function automatic mrrf_pkg::rec_t to_rec(input cand_t c);
		logic [IW+mrrf_pkg::ROW_W-1:0]  row_x;
		logic [IW+mrrf_pkg::COL_W-1:0]  col_x;
		logic [SW+mrrf_pkg::HGT_W-1:0]  hgt_x;
		logic [SW+mrrf_pkg::WID_W-1:0]  wid_x;
		logic [PW+mrrf_pkg::AREA_W-1:0] area_x;
		mrrf_pkg::rec_t r;
		row_x  = {{mrrf_pkg::ROW_W{1'b0}}, c.row};
		col_x  = {{mrrf_pkg::COL_W{1'b0}}, c.col};
		hgt_x  = {{mrrf_pkg::HGT_W{1'b0}}, c.height};
		wid_x  = {{mrrf_pkg::WID_W{1'b0}}, c.width};
		area_x = {{mrrf_pkg::AREA_W{1'b0}}, c.area};
		r.top_row       = row_x[mrrf_pkg::ROW_W-1:0];
		r.left_col      = col_x[mrrf_pkg::COL_W-1:0];
		r.region_height = hgt_x[mrrf_pkg::HGT_W-1:0];
		r.region_width  = wid_x[mrrf_pkg::WID_W-1:0];
		r.region_area   = area_x[mrrf_pkg::AREA_W-1:0];
		return r;
	endfunction

	mrrf_pkg::scan_state_t state_q, state_d;

	logic [IW-1:0] i_q, j_q, mx_q, my_q;
	logic [SW-1:0] w_q, h_q;
	logic [AW-1:0] cur_q, probe_q, probe_d, mrow_q, mark_q;
	logic [PW-1:0] area_q;
	cand_t         best_h_q, best_w_q, best_a_q, cand;

	logic [EW-1:0] i_e, j_e, w_e, h_e, rows_e, cols_e;
	logic [AW-1:0] cols_a;
	logic          j_fit, w_fit, i_fit, h_fit, row_end, scan_last;
	logic          start_cell, mark_row_end, mark_last;

	assign i_e    = EW'(i_q);
	assign j_e    = EW'(j_q);
	assign w_e    = EW'(w_q);
	assign h_e    = EW'(h_q);
	assign rows_e = EW'(num_rows);
	assign cols_e = EW'(num_cols);
	assign cols_a = AW'(num_cols);

	assign j_fit        = (j_e + EW'(1)) < cols_e;
	assign w_fit        = (j_e + w_e + EW'(1)) < cols_e;
	assign i_fit        = (i_e + EW'(1)) < rows_e;
	assign h_fit        = (i_e + h_e + EW'(1)) < rows_e;
	assign row_end      = (j_e + EW'(1)) == cols_e;
	assign scan_last    = row_end && ((i_e + EW'(1)) == rows_e);
	assign start_cell   = img_bit && !vis_bit;
	assign mark_row_end = (EW'(my_q) + EW'(1)) == w_e;
	assign mark_last    = mark_row_end && ((EW'(mx_q) + EW'(1)) == h_e);

	assign cand = '{row: i_q, col: j_q, height: h_q, width: w_q, area: area_q};

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mrrf_pkg::SC_IDLE: begin
				if (start) state_d = mrrf_pkg::SC_READ;
			end
			mrrf_pkg::SC_READ: state_d = mrrf_pkg::SC_CHECK;
			mrrf_pkg::SC_CHECK: begin
				if (start_cell) begin
					if (j_fit)      state_d = mrrf_pkg::SC_WIDTH;
					else if (i_fit) state_d = mrrf_pkg::SC_HEIGHT;
					else            state_d = mrrf_pkg::SC_MARK;
				end else if (scan_last) begin
					state_d = mrrf_pkg::SC_IDLE;
				end
			end
			mrrf_pkg::SC_WIDTH: begin
				if (!(img_bit && w_fit)) begin
					state_d = i_fit ? mrrf_pkg::SC_HEIGHT : mrrf_pkg::SC_MARK;
				end
			end
			mrrf_pkg::SC_HEIGHT: begin
				if (!(img_bit && h_fit)) state_d = mrrf_pkg::SC_MARK;
			end
			mrrf_pkg::SC_MARK: begin
				if (mark_last) state_d = mrrf_pkg::SC_UPDATE;
			end
			mrrf_pkg::SC_UPDATE: begin
				state_d = scan_last ? mrrf_pkg::SC_IDLE : mrrf_pkg::SC_CHECK;
			end
			default: state_d = mrrf_pkg::SC_IDLE;
		endcase
	end

	// outputs: read address for the next cycle, mark write, status
	always_comb begin
		probe_d   = probe_q;
		mark_we   = 1'b0;
		stat.busy = (state_q != mrrf_pkg::SC_IDLE);
		stat.done = 1'b0;
		unique case (state_q)
			mrrf_pkg::SC_IDLE: ;
			mrrf_pkg::SC_READ: probe_d = cur_q;
			mrrf_pkg::SC_CHECK: begin
				if (start_cell) begin
					if (j_fit)      probe_d = cur_q + AW'(1);
					else if (i_fit) probe_d = cur_q + cols_a;
				end else if (scan_last) begin
					stat.done = 1'b1;
				end else begin
					probe_d = cur_q + AW'(1);
				end
			end
			mrrf_pkg::SC_WIDTH: begin
				if (img_bit && w_fit) probe_d = probe_q + AW'(1);
				else if (i_fit)       probe_d = cur_q + cols_a;
			end
			mrrf_pkg::SC_HEIGHT: begin
				if (img_bit && h_fit) probe_d = probe_q + cols_a;
			end
			mrrf_pkg::SC_MARK: mark_we = 1'b1;
			mrrf_pkg::SC_UPDATE: begin
				if (scan_last) stat.done = 1'b1;
				else           probe_d = cur_q + AW'(1);
			end
			default: ;
		endcase
	end

	assign rd_addr   = probe_d;
	assign mark_addr = mark_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mrrf_pkg::SC_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		probe_q <= probe_d;
		unique case (state_q)
			mrrf_pkg::SC_IDLE: begin
				if (start) begin
					i_q      <= '0;
					j_q      <= '0;
					cur_q    <= '0;
					best_h_q <= '0;
					best_w_q <= '0;
					best_a_q <= '0;
				end
			end
			mrrf_pkg::SC_READ: ;
			mrrf_pkg::SC_CHECK: begin
				if (start_cell) begin
					w_q    <= SW'(1);
					h_q    <= SW'(1);
					mark_q <= cur_q;
					mrow_q <= cur_q;
					mx_q   <= '0;
					my_q   <= '0;
				end else if (!scan_last) begin
					cur_q <= cur_q + AW'(1);
					if (row_end) begin
						j_q <= '0;
						i_q <= i_q + IW'(1);
					end else begin
						j_q <= j_q + IW'(1);
					end
				end
			end
			mrrf_pkg::SC_WIDTH: begin
				if (img_bit) w_q <= w_q + SW'(1);
			end
			mrrf_pkg::SC_HEIGHT: begin
				if (img_bit) h_q <= h_q + SW'(1);
			end
			mrrf_pkg::SC_MARK: begin
				area_q <= PW'(h_q) * PW'(w_q);
				if (mark_row_end) begin
					my_q   <= '0;
					mx_q   <= mx_q + IW'(1);
					mrow_q <= mrow_q + cols_a;
					mark_q <= mrow_q + cols_a;
				end else begin
					my_q   <= my_q + IW'(1);
					mark_q <= mark_q + AW'(1);
				end
			end
			mrrf_pkg::SC_UPDATE: begin
				// strictly greater only, earlier region wins a tie
				if (h_q > best_h_q.height) best_h_q <= cand;
				if (w_q > best_w_q.width)  best_w_q <= cand;
				if (area_q > best_a_q.area) best_a_q <= cand;
				if (!scan_last) begin
					cur_q <= cur_q + AW'(1);
					if (row_end) begin
						j_q <= '0;
						i_q <= i_q + IW'(1);
					end else begin
						j_q <= j_q + IW'(1);
					end
				end
			end
			default: ;
		endcase
	end

	assign rec_height = to_rec(best_h_q);
	assign rec_width  = to_rec(best_w_q);
	assign rec_area   = to_rec(best_a_q);

	`MRRF_ASSERT_IMP(a_start_when_idle, clk, arst_n, start, state_q == mrrf_pkg::SC_IDLE, "scan start while busy")
	`MRRF_ASSERT_IMP(a_width_in_frame, clk, arst_n, state_q == mrrf_pkg::SC_MARK, (j_e + w_e) <= cols_e, "region wider than frame")
	`MRRF_ASSERT_IMP(a_height_in_frame, clk, arst_n, state_q == mrrf_pkg::SC_MARK, (i_e + h_e) <= rows_e, "region taller than frame")

endmodule

`default_nettype wire

>>> sv/mrrf_out.sv
// ----------------------------------------------------------------------------
// mrrf_out
// output register that presents the three records of a frame in order
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mrrf_out (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  mrrf_pkg::rec_t                rec_height,
	input  mrrf_pkg::rec_t                rec_width,
	input  mrrf_pkg::rec_t                rec_area,
	output logic                          busy,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [39:0]                   m_tdata,
	output logic [mrrf_pkg::CAT_W-1:0]    m_tuser,
	output logic                          m_tlast
);

	logic [1:0]                 pend_q;
	logic                       tvalid_q, last_q, advance;
	logic [mrrf_pkg::CAT_W-1:0] idx, cat_q;
	mrrf_pkg::rec_t             sel, rec_q;

	// records not yet moved into the output register
	assign idx     = mrrf_pkg::CAT_W'(mrrf_pkg::NUM_RECORDS) - pend_q;
	assign advance = (pend_q != 2'd0) && (!tvalid_q || m_tready);
	assign busy    = (pend_q != 2'd0);

	always_comb begin
		case (idx)
			mrrf_pkg::CAT_HEIGHT: sel = rec_height;
			mrrf_pkg::CAT_WIDTH:  sel = rec_width;
			default:              sel = rec_area;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q   <= 2'd0;
			tvalid_q <= 1'b0;
		end else begin
			if (load) begin
				pend_q <= 2'(mrrf_pkg::NUM_RECORDS);
			end else if (advance) begin
				pend_q <= pend_q - 2'd1;
			end
			if (advance) begin
				tvalid_q <= 1'b1;
			end else if (m_tready) begin
				tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rec_q  <= sel;
			cat_q  <= idx;
			last_q <= (idx == mrrf_pkg::CAT_AREA);
		end
	end

	assign m_tvalid = tvalid_q;
	assign m_tdata  = {1'b0, rec_q.region_area, rec_q.region_width, rec_q.region_height,
		rec_q.left_col, rec_q.top_row};
	assign m_tuser  = cat_q;
	assign m_tlast  = last_q;

	`MRRF_ASSERT_IMP(a_load_when_empty, clk, arst_n, load, pend_q == 2'd0, "records overwritten")
	`MRRF_ASSERT_IMP(a_last_is_area, clk, arst_n, tvalid_q && last_q, cat_q == mrrf_pkg::CAT_AREA, "last record not area")

endmodule

`default_nettype wire

>>> sv/max_rectangle_region_finder.sv
// ----------------------------------------------------------------------------
// max_rectangle_region_finder
// loads a binary frame into ram, scans it for rectangle regions and reports
// the tallest, widest and largest region of each frame
// ----------------------------------------------------------------------------
//  channel  | dir | handshake           | payload
//  s_*      | in  | s_tvalid / s_tready | s_tdata: pixel
//  m_*      | out | m_tvalid / m_tready | m_tdata: region record, m_tuser: category,
//           |     |                     | m_tlast: last record of the frame
//  cfg_*    | in  | cfg_we              | cfg_index, cfg_data
//
//  loading takes one pixel item per cycle while s_tready is high, written into the
//  image and visited rams; the scan runs after the last pixel: a read to start, a
//  check per skipped cell, and per region a check, probe reads, one visited write
//  per covered cell through the single ram write port, and an update
//  visited flags are cleared as pixels load, so no clearing pass after reset
//  s_tready is low during the scan and until the third record of a frame is
//  in the output register; the third record may wait while the next frame loads
// ----------------------------------------------------------------------------
`default_nettype none

module max_rectangle_region_finder #(
	parameter int MAX_SIDE = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [7:0]                       s_tdata,   // [0] pixel
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [39:0]                      m_tdata,   // [5:0] top_row, [11:6] left_col,
	                                                    // [18:12] region_height,
	                                                    // [25:19] region_width,
	                                                    // [38:26] region_area
	output logic [mrrf_pkg::CAT_W-1:0]       m_tuser,   // [1:0] category
	output logic                             m_tlast,
	input  logic                             cfg_we,
	input  logic [mrrf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mrrf_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int CELLS      = MAX_SIDE * MAX_SIDE;
	localparam int AW         = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int SW         = $clog2(MAX_SIDE + 1);
	localparam int IW         = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
	localparam int RESET_SIDE = (MAX_SIDE < 64) ? MAX_SIDE : 64;

	function automatic logic [SW-1:0] clamp_side(input logic [mrrf_pkg::CFG_DATA_W-1:0] v);
		logic [8:0] wide;
		wide = 9'(v);
		if (v == '0)                  return SW'(1);
		else if (wide > 9'(MAX_SIDE)) return SW'(MAX_SIDE);
		else                          return SW'(v);
	endfunction

	logic [SW-1:0]        rows_q, cols_q;
	logic [AW-1:0]        lpos_q;
	logic [IW-1:0]        lrow_q, lcol_q;
	logic                 pix_acc, col_end, load_last, out_busy;
	logic                 img_bit, vis_bit, mark_we, vis_we, vis_wdata;
	logic [AW-1:0]        rd_addr, mark_addr, vis_waddr;
	mrrf_pkg::scan_stat_t scan_stat;
	mrrf_pkg::rec_t       rec_height, rec_width, rec_area;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= SW'(RESET_SIDE);
			cols_q <= SW'(RESET_SIDE);
		end else if (cfg_we) begin
			unique case (cfg_index)
				mrrf_pkg::REG_NUM_ROWS: rows_q <= clamp_side(cfg_data);
				mrrf_pkg::REG_NUM_COLS: cols_q <= clamp_side(cfg_data);
				default: ;
			endcase
		end
	end

	assign s_tready  = !scan_stat.busy && !out_busy;
	assign pix_acc   = s_tvalid && s_tready;
	assign col_end   = SW'(lcol_q) == (cols_q - SW'(1));
	assign load_last = col_end && (SW'(lrow_q) == (rows_q - SW'(1)));

	// load position, dropped on any register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lpos_q <= '0;
			lrow_q <= '0;
			lcol_q <= '0;
		end else if (cfg_we || (pix_acc && load_last)) begin
			lpos_q <= '0;
			lrow_q <= '0;
			lcol_q <= '0;
		end else if (pix_acc) begin
			lpos_q <= lpos_q + AW'(1);
			if (col_end) begin
				lcol_q <= '0;
				lrow_q <= lrow_q + IW'(1);
			end else begin
				lcol_q <= lcol_q + IW'(1);
			end
		end
	end

	assign vis_we    = pix_acc || mark_we;
	assign vis_waddr = mark_we ? mark_addr : lpos_q;
	assign vis_wdata = mark_we;

	mrrf_ram #(
		.WIDTH (1),
		.DEPTH (CELLS)
	) u_image_ram (
		.clk   (clk),
		.we    (pix_acc),
		.waddr (lpos_q),
		.wdata (s_tdata[0]),
		.raddr (rd_addr),
		.rdata (img_bit)
	);

	mrrf_ram #(
		.WIDTH (1),
		.DEPTH (CELLS)
	) u_visited_ram (
		.clk   (clk),
		.we    (vis_we),
		.waddr (vis_waddr),
		.wdata (vis_wdata),
		.raddr (rd_addr),
		.rdata (vis_bit)
	);

	mrrf_scan #(
		.MAX_SIDE (MAX_SIDE)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (pix_acc && load_last),
		.num_rows   (rows_q),
		.num_cols   (cols_q),
		.rd_addr    (rd_addr),
		.img_bit    (img_bit),
		.vis_bit    (vis_bit),
		.mark_we    (mark_we),
		.mark_addr  (mark_addr),
		.stat       (scan_stat),
		.rec_height (rec_height),
		.rec_width  (rec_width),
		.rec_area   (rec_area)
	);

	mrrf_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (scan_stat.done),
		.rec_height (rec_height),
		.rec_width  (rec_width),
		.rec_area   (rec_area),
		.busy       (out_busy),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

endmodule

`default_nettype wire

>>> bench/max_rectangle_region_finder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_rectangle_region_finder_tb
// streams binary frames of many sizes into the region finder, computes the
// tallest, widest and largest region of each frame alongside it and checks
// every record field by field, with random idling on both streams
// ----------------------------------------------------------------------------

module max_rectangle_region_finder_tb;

	localparam int SIDE           = 64;
	localparam int IDLE_PCT       = 35;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int RANDOM_PIXELS  = 60;

	typedef struct {
		logic [mrrf_pkg::CAT_W-1:0] category;
		mrrf_pkg::rec_t             region;
		logic                       last;
	} region_record_t;

	typedef struct {
		int row;
		int col;
		int height;
		int width;
		int area;
	} rect_t;

	logic                            clk       = 1'b0;
	logic                            arst_n    = 1'b0;
	logic                            s_tvalid  = 1'b0;
	logic                            s_tready;
	logic [7:0]                      s_tdata   = '0;
	logic                            m_tvalid;
	logic                            m_tready  = 1'b0;
	logic [39:0]                     m_tdata;
	logic [mrrf_pkg::CAT_W-1:0]      m_tuser;
	logic                            m_tlast;
	logic                            cfg_we    = 1'b0;
	logic [mrrf_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [mrrf_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

	bit             steady        = 1'b0;
	int             mismatches    = 0;
	int             stall_cycles  = 0;
	int             pixels_sent   = 0;
	region_record_t expected_records[$];

	int frame_rows = SIDE;
	int frame_cols = SIDE;
	int fill_count = 0;
	bit frame_bits [SIDE*SIDE];

	max_rectangle_region_finder #(.MAX_SIDE(SIDE)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int fit_side(input logic [mrrf_pkg::CFG_DATA_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > SIDE)
			return SIDE;
		return int'(v);
	endfunction

	function automatic void queue_record(input logic [mrrf_pkg::CAT_W-1:0] cat, input rect_t r,
		input logic last);
		region_record_t e;
		e.category             = cat;
		e.region.top_row       = mrrf_pkg::ROW_W'(r.row);
		e.region.left_col      = mrrf_pkg::COL_W'(r.col);
		e.region.region_height = mrrf_pkg::HGT_W'(r.height);
		e.region.region_width  = mrrf_pkg::WID_W'(r.width);
		e.region.region_area   = mrrf_pkg::AREA_W'(r.area);
		e.last                 = last;
		expected_records.push_back(e);
	endfunction

	function automatic void find_regions();
		bit    covered [SIDE*SIDE];
		rect_t tallest;
		rect_t widest;
		rect_t largest;
		rect_t cand;
		int    h;
		int    w;
		covered = '{default: 1'b0};
		tallest = '{default: 0};
		widest  = '{default: 0};
		largest = '{default: 0};
		for (int r = 0; r < frame_rows; r++) begin
			for (int c = 0; c < frame_cols; c++) begin
				if (!frame_bits[r*frame_cols+c] || covered[r*frame_cols+c])
					continue;
				w = 0;
				while (c + w < frame_cols && frame_bits[r*frame_cols+c+w])
					w++;
				h = 0;
				while (r + h < frame_rows && frame_bits[(r+h)*frame_cols+c])
					h++;
				// the whole rectangle is covered, holes included
				for (int y = r; y < r + h; y++)
					for (int x = c; x < c + w; x++)
						covered[y*frame_cols+x] = 1'b1;
				cand = '{r, c, h, w, h * w};
				if (cand.height > tallest.height)
					tallest = cand;
				if (cand.width > widest.width)
					widest = cand;
				if (cand.area > largest.area)
					largest = cand;
			end
		end
		queue_record(mrrf_pkg::CAT_HEIGHT, tallest, 1'b0);
		queue_record(mrrf_pkg::CAT_WIDTH, widest, 1'b0);
		queue_record(mrrf_pkg::CAT_AREA, largest, 1'b1);
	endfunction

	function automatic void absorb_pixel(input bit px);
		if (fill_count >= frame_rows * frame_cols)
			fill_count = 0;
		frame_bits[fill_count] = px;
		fill_count++;
		if (fill_count == frame_rows * frame_cols) begin
			find_regions();
			fill_count = 0;
		end
	endfunction

	function automatic void compare_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// record checker
	always @(posedge clk) begin : check_records
		region_record_t want;
		mrrf_pkg::rec_t got;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_records.size() == 0) begin
				$error("unexpected record: tuser %0d tdata %h", m_tuser, m_tdata);
				mismatches++;
			end else begin
				want = expected_records.pop_front();
				got  = mrrf_pkg::rec_t'(m_tdata[38:0]);
				compare_field("category", want.category, m_tuser);
				compare_field("top_row", want.region.top_row, got.top_row);
				compare_field("left_col", want.region.left_col, got.left_col);
				compare_field("region_height", want.region.region_height, got.region_height);
				compare_field("region_width", want.region.region_width, got.region_width);
				compare_field("region_area", want.region.region_area, got.region_area);
				compare_field("last_record", want.last, m_tlast);
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else if (steady)
			m_tready <= 1'b1;
		else
			m_tready <= ($urandom_range(99) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles == WATCHDOG_LIMIT) begin
				$display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	task automatic push_pixel(input bit px);
		@(negedge clk);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'($urandom), px};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		absorb_pixel(px);
		pixels_sent++;
	endtask

	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_records.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [mrrf_pkg::CFG_IDX_W-1:0] idx,
		input logic [mrrf_pkg::CFG_DATA_W-1:0] val);
		settle();
		repeat (8) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == mrrf_pkg::REG_NUM_ROWS)
			frame_rows = fit_side(val);
		else
			frame_cols = fit_side(val);
		fill_count = 0;
	endtask

	task automatic resize(input logic [mrrf_pkg::CFG_DATA_W-1:0] rows,
		input logic [mrrf_pkg::CFG_DATA_W-1:0] cols);
		write_reg(mrrf_pkg::REG_NUM_ROWS, rows);
		write_reg(mrrf_pkg::REG_NUM_COLS, cols);
	endtask

	task automatic send_pattern(input int n, input logic [63:0] bits);
		for (int i = 0; i < n; i++)
			push_pixel(bits[i]);
	endtask

	task automatic send_random_frame(input int density);
		for (int i = 0; i < frame_rows * frame_cols; i++)
			push_pixel($urandom_range(99) < density);
	endtask

	task automatic test_single_pixel();
		resize(1, 1);
		push_pixel(1'b0);
		push_pixel(1'b1);
		settle();
	endtask

	task automatic test_shapes();
		resize(3, 3);
		// two equal columns, the earlier one wins
		send_pattern(9, 64'h02D);
		// wide top row covers the blank cells below it
		send_pattern(9, 64'h04F);
		// partial frame dropped by a register write
		send_pattern(4, 64'hF);
		write_reg(mrrf_pkg::REG_NUM_COLS, 3);
		send_pattern(9, 64'h0F6);
		settle();
	endtask

	task automatic test_size_extremes();
		// out of range values clamp to a full-width row, then a full-height column
		resize(0, 127);
		send_pattern(64, '1);
		resize(65, 0);
		send_pattern(64, '1);
		settle();
	endtask

	task automatic test_back_to_back();
		resize(4, 5);
		steady = 1'b1;
		repeat (3) send_random_frame(60);
		settle();
		steady = 1'b0;
	endtask

	task automatic test_random_frames();
		int start;
		int frames;
		int cut;
		int density;
		start  = pixels_sent;
		frames = 0;
		while (pixels_sent - start < RANDOM_PIXELS || frames < 6) begin
			if (frames == 0 || $urandom_range(3) != 0) begin
				if ($urandom_range(7) == 0)
					resize(7'($urandom_range(6, 8)), 7'($urandom_range(6, 8)));
				else
					resize(7'($urandom_range(1, 5)), 7'($urandom_range(1, 5)));
			end else if ($urandom_range(4) == 0) begin
				settle();
			end
			if ($urandom_range(7) == 0) begin
				cut = $urandom_range(frame_rows * frame_cols) - 1;
				for (int i = 0; i < cut; i++)
					push_pixel($urandom_range(1));
				write_reg(mrrf_pkg::REG_NUM_ROWS, 7'(frame_rows));
			end
			case ($urandom_range(3))
				0: density = 15;
				1: density = 50;
				2: density = 85;
				default: density = 100;
			endcase
			send_random_frame(density);
			frames++;
		end
		settle();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_single_pixel();
		test_shapes();
		test_size_extremes();
		test_back_to_back();
		test_random_frames();
		settle();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_records.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> files.f
+incdir+sv
sv/mrrf_pkg.sv
sv/mrrf_ram.sv
sv/mrrf_scan.sv
sv/mrrf_out.sv
sv/max_rectangle_region_finder.sv
bench/max_rectangle_region_finder_tb.sv
